FILE: src/cng_pkg.sv
// shared types and constants for the next combination generator
`timescale 1ns / 1ps

package cng_pkg;

  localparam int K_MAX = 16;
  localparam int POS_W = 4;
  localparam int VAL_W = 6;
  localparam int N_W = 7;
  localparam int K_W = 5;
  localparam int OP_W = 2;
  localparam int IDX_W = 2;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 16;

  localparam logic [N_W-1:0] N_SAT = N_W'(64);
  localparam logic [K_W-1:0] K_SAT = K_W'(K_MAX);
  localparam logic [N_W-1:0] N_RESET = N_W'(5);
  localparam logic [K_W-1:0] K_RESET = K_W'(3);

  typedef enum logic [OP_W-1:0] {
    OP_ADVANCE = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_LOAD    = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_TOTAL_VALUES = 2'd0,
    REG_CHOSEN_COUNT = 2'd1
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    logic             shift;
    logic             clear;
    logic             load;
    logic [POS_W-1:0] load_pos;
    logic [VAL_W-1:0] load_val;
    logic             adv;
    logic             any_hit;
    logic [VAL_W-1:0] adv_base;
    logic [VAL_W-1:0] wrap_base;
    logic [K_W-1:0]   k;
  } cell_cmd_t;

endpackage

FILE: src/next_combination_generator.sv
// top level: config registers, sequencer and the rotating chain of element cells
// an item's first element is offered in the cycle after the item is taken
// no new item is taken until the 16-cell chain has made a full rotation, emitting the
//   first k cells and restoring the order; output stalls hold the rotation
// reset: synchronous; all elements zero, n = 5, k = 3, block idle and ready
`timescale 1ns / 1ps

module next_combination_generator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cng_pkg::IDX_W-1:0]        cfg_index,
  input  logic [cng_pkg::N_W-1:0]          cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // opcode[1:0], position[5:2], value[11:6], zero fill
  input  logic [cng_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // elem_position[3:0], elem_value[9:4], zero fill
  output logic [cng_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic                             m_tlast,
  // wrapped[0]
  output logic [0:0]                       m_tuser
);

  logic [cng_pkg::N_W-1:0]   total_values;
  logic [cng_pkg::K_W-1:0]   chosen_count;
  logic [cng_pkg::N_W-1:0]   n_eff;
  logic [cng_pkg::K_W-1:0]   k_sat;
  logic [cng_pkg::K_W-1:0]   k_eff;
  cng_pkg::state_t           state;
  cng_pkg::state_t           state_next;
  logic [cng_pkg::POS_W-1:0] cnt;
  logic                      wrapped;
  logic                      accept;
  logic                      step;
  logic                      emitting;
  cng_pkg::opcode_t          op;
  cng_pkg::cell_cmd_t        cmd;
  logic [cng_pkg::VAL_W-1:0] adv_base;
  logic [cng_pkg::VAL_W-1:0] vals  [cng_pkg::K_MAX];
  logic [cng_pkg::VAL_W-1:0] cands [cng_pkg::K_MAX];
  logic [cng_pkg::K_MAX:0]   found;

  // config port, open only while no run is in progress
  assign cfg_ready = (state == cng_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      total_values <= cng_pkg::N_RESET;
      chosen_count <= cng_pkg::K_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cng_pkg::REG_TOTAL_VALUES: total_values <= cfg_data;
        cng_pkg::REG_CHOSEN_COUNT: chosen_count <= cfg_data[cng_pkg::K_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_eff = (total_values > cng_pkg::N_SAT) ? cng_pkg::N_SAT : total_values;
  assign k_sat = (chosen_count > cng_pkg::K_SAT) ? cng_pkg::K_SAT : chosen_count;
  assign k_eff = (cng_pkg::N_W'(k_sat) > n_eff) ? cng_pkg::K_W'(n_eff) : k_sat;

  // sequencer
  assign s_tready = (state == cng_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign op       = cng_pkg::opcode_t'(s_tdata[1:0]);
  assign emitting = (state == cng_pkg::ST_RUN) && (cng_pkg::K_W'(cnt) < k_eff);
  assign step     = (state == cng_pkg::ST_RUN) && (!emitting || m_tready);

  always_comb begin
    state_next = state;
    case (state)
      cng_pkg::ST_IDLE: if (accept) state_next = cng_pkg::ST_RUN;
      cng_pkg::ST_RUN:  if (step && (cnt == cng_pkg::POS_W'(cng_pkg::K_MAX - 1)))
                          state_next = cng_pkg::ST_IDLE;
      default:          state_next = cng_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= cng_pkg::ST_IDLE;
      cnt     <= '0;
      wrapped <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt     <= '0;
        wrapped <= (op == cng_pkg::OP_ADVANCE) && !found[cng_pkg::K_MAX] && (k_eff != '0);
      end else if (step) begin
        cnt <= cnt + cng_pkg::POS_W'(1);
      end
    end
  end

  // lowest hit selects the advance base
  always_comb begin
    adv_base = '0;
    for (int i = 0; i < cng_pkg::K_MAX; i++) begin
      adv_base = adv_base | cands[i];
    end
  end

  always_comb begin
    cmd.shift     = step;
    cmd.clear     = accept && (op == cng_pkg::OP_CLEAR);
    cmd.load      = accept && (op == cng_pkg::OP_LOAD);
    cmd.load_pos  = s_tdata[5:2];
    cmd.load_val  = s_tdata[11:6];
    cmd.adv       = accept && (op == cng_pkg::OP_ADVANCE);
    cmd.any_hit   = found[cng_pkg::K_MAX];
    cmd.adv_base  = adv_base;
    cmd.wrap_base = cng_pkg::VAL_W'(n_eff - cng_pkg::N_W'(k_eff));
    cmd.k         = k_eff;
  end

  assign found[0] = 1'b0;

  for (genvar i = 0; i < cng_pkg::K_MAX; i++) begin : g_cell
    cng_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (cng_pkg::POS_W'(i)),
      .cmd       (cmd),
      .nbr       (vals[(i + 1) % cng_pkg::K_MAX]),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .value     (vals[i]),
      .cand      (cands[i])
    );
  end

  // output from the head of the chain
  assign m_tvalid   = emitting;
  assign m_tdata    = {{(cng_pkg::OUT_TDATA_W - cng_pkg::POS_W - cng_pkg::VAL_W){1'b0}},
                       vals[0], cnt};
  assign m_tlast    = (cng_pkg::K_W'(cnt) == (k_eff - cng_pkg::K_W'(1)));
  assign m_tuser[0] = wrapped;

endmodule

FILE: src/cng_cell.sv
// one element of the combination chain with its advance, rotate, clear and load logic
`timescale 1ns / 1ps

module cng_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [cng_pkg::POS_W-1:0] idx,
  input  cng_pkg::cell_cmd_t       cmd,
  input  logic [cng_pkg::VAL_W-1:0] nbr,
  input  logic                     found_in,
  output logic                     found_out,
  output logic [cng_pkg::VAL_W-1:0] value,
  output logic [cng_pkg::VAL_W-1:0] cand
);

  logic                      active;
  logic                      hit;
  logic                      first_hit;
  logic [cng_pkg::VAL_W-1:0] idx_ext;
  logic [cng_pkg::VAL_W-1:0] value_next;

  assign idx_ext   = cng_pkg::VAL_W'(idx);
  assign active    = cng_pkg::K_W'(idx) < cmd.k;
  assign hit       = active && (value > idx_ext);
  assign first_hit = hit && !found_in;
  assign found_out = found_in || hit;
  assign cand      = first_hit ? (value - idx_ext - cng_pkg::VAL_W'(1)) : '0;

  always_comb begin
    value_next = value;
    if (cmd.shift) begin
      value_next = nbr;
    end else if (cmd.clear) begin
      value_next = '0;
    end else if (cmd.load && (cmd.load_pos == idx)) begin
      value_next = cmd.load_val;
    end else if (cmd.adv) begin
      if (cmd.any_hit && !found_in) begin
        value_next = cmd.adv_base + idx_ext;
      end else if (!cmd.any_hit && active) begin
        value_next = cmd.wrap_base + idx_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else begin
      value <= value_next;
    end
  end

endmodule

FILE: src/cng_checker.sv
// port-level checks for the next combination generator, bound to the top level
`timescale 1ns / 1ps

module cng_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [cng_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input logic                             m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a run is in progress");

  a_out_only_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("output offered while idle");

  a_run_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && (m_tdata[3:0] == 4'($past(m_tdata[3:0]) + 4'd1)))
    else $error("run positions not consecutive");

endmodule

bind next_combination_generator cng_checker u_cng_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

FILE: test/tb_top.sv
// testbench for the next combination generator: directed table, then randomized phases
`timescale 1ns / 1ps

module tb_top;

  localparam int DIRECT_K = 3;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;
  localparam logic [cng_pkg::IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [cng_pkg::POS_W-1:0] pos;
    logic [cng_pkg::VAL_W-1:0] val;
    logic                      last;
    logic                      wrapped;
  } elem_t;

  typedef struct {
    cng_pkg::opcode_t          op;
    logic [cng_pkg::POS_W-1:0] pos;
    logic [cng_pkg::VAL_W-1:0] val;
    bit                        typed;
    logic                      wrap;
    logic [cng_pkg::VAL_W-1:0] v0, v1, v2;
  } row_t;

  typedef struct {
    logic [cng_pkg::N_W-1:0] n;
    logic [cng_pkg::K_W-1:0] k;
    int                      count;
    int                      mode;
    bit                      hold;
    bit                      pause;
  } phase_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [cng_pkg::IDX_W-1:0]       cfg_index = '0;
  logic [cng_pkg::N_W-1:0]         cfg_data = '0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [cng_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [cng_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            m_tlast;
  logic [0:0]                      m_tuser;

  next_combination_generator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [cng_pkg::N_W-1:0]   total_n = cng_pkg::N_RESET;
  logic [cng_pkg::K_W-1:0]   chosen_k = cng_pkg::K_RESET;
  logic [cng_pkg::VAL_W-1:0] comb_now [cng_pkg::K_MAX];
  elem_t                     pending_elems [$];

  int mismatches = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  elem_t want;

  row_t script [19] = '{
    '{cng_pkg::OP_ADVANCE, 4'd0,  6'd0,  1'b1, 1'b1, 6'd2,  6'd3, 6'd4},
    '{cng_pkg::OP_ADVANCE, 4'd0,  6'd0,  1'b1, 1'b0, 6'd1,  6'd3, 6'd4},
    '{cng_pkg::OP_ADVANCE, 4'd0,  6'd0,  1'b0, 1'b0, 6'd0,  6'd0, 6'd0},
    '{cng_pkg::OP_ADVANCE, 4'd0,  6'd0,  1'b0, 1'b0, 6'd0,  6'd0, 6'd0},
    '{cng_pkg::OP_CLEAR,   4'd15, 6'd63, 1'b1, 1'b0, 6'd0,  6'd0, 6'd0},
    '{cng_pkg::OP_ADVANCE, 4'd0,  6'd0,  1'b1, 1'b1, 6'd2,  6'd3, 6'd4},
    '{cng_pkg::OP_LOAD,    4'd15, 6'd63, 1'b1, 1'b0, 6'd2,  6'd3, 6'd4},
    '{cng_pkg::OP_LOAD,    4'd0,  6'd63, 1'b1, 1'b0, 6'd63, 6'd3, 6'd4},
    '{cng_pkg::OP_NONE,    4'd15, 6'd63, 1'b1, 1'b0, 6'd63, 6'd3, 6'd4},
    '{cng_pkg::OP_ADVANCE, 4'd0,  6'd0,  1'b0, 1'b0, 6'd0,  6'd0, 6'd0},
    '{cng_pkg::OP_LOAD,    4'd2,  6'd0,  1'b0, 1'b0, 6'd0,  6'd0, 6'd0},
    '{cng_pkg::OP_LOAD,    4'd1,  6'd0,  1'b0, 1'b0, 6'd0,  6'd0, 6'd0},
    '{cng_pkg::OP_LOAD,    4'd0,  6'd0,  1'b0, 1'b0, 6'd0,  6'd0, 6'd0},
    '{cng_pkg::OP_LOAD,    4'd2,  6'd5,  1'b0, 1'b0, 6'd0,  6'd0, 6'd0},
    '{cng_pkg::OP_ADVANCE, 4'd0,  6'd0,  1'b0, 1'b0, 6'd0,  6'd0, 6'd0},
    '{cng_pkg::OP_LOAD,    4'd9,  6'd42, 1'b0, 1'b0, 6'd0,  6'd0, 6'd0},
    '{cng_pkg::OP_LOAD,    4'd6,  6'd21, 1'b0, 1'b0, 6'd0,  6'd0, 6'd0},
    '{cng_pkg::OP_LOAD,    4'd5,  6'd63, 1'b0, 1'b0, 6'd0,  6'd0, 6'd0},
    '{cng_pkg::OP_CLEAR,   4'd0,  6'd0,  1'b1, 1'b0, 6'd0,  6'd0, 6'd0}
  };

  phase_t plan [11] = '{
    '{7'd64,  5'd16, 8,  0, 1'b0, 1'b0},
    '{7'd1,   5'd1,  10, 1, 1'b0, 1'b0},
    '{7'd127, 5'd31, 6,  2, 1'b0, 1'b0},
    '{7'd0,   5'd3,  5,  3, 1'b0, 1'b0},
    '{7'd7,   5'd0,  5,  0, 1'b0, 1'b0},
    '{7'd4,   5'd16, 10, 1, 1'b0, 1'b1},
    '{7'd20,  5'd5,  15, 2, 1'b0, 1'b0},
    '{7'd9,   5'd2,  12, 3, 1'b0, 1'b0},
    '{7'd10,  5'd4,  14, 0, 1'b1, 1'b0},
    '{7'd64,  5'd1,  10, 1, 1'b0, 1'b0},
    '{7'd2,   5'd2,  8,  2, 1'b0, 1'b0}
  };

  int send_pct_of [4] = '{0, 78, 0, 13};
  int recv_pct_of [4] = '{0, 0, 78, 13};

  initial begin
    foreach (comb_now[i]) comb_now[i] = '0;
  end

  // updates the predicted combination and, when push_it is set, queues the run the item causes
  function automatic void compute_run(input cng_pkg::opcode_t op,
                                      input logic [cng_pkg::POS_W-1:0] pos,
                                      input logic [cng_pkg::VAL_W-1:0] val,
                                      input bit push_it);
    int n_eff, k_eff, p, q, v;
    bit hit, wrap;
    n_eff = (total_n > cng_pkg::N_SAT) ? int'(cng_pkg::N_SAT) : int'(total_n);
    k_eff = (chosen_k > cng_pkg::K_SAT) ? int'(cng_pkg::K_SAT) : int'(chosen_k);
    if (k_eff > n_eff) k_eff = n_eff;
    hit = 1'b0;
    wrap = 1'b0;
    case (op)
      cng_pkg::OP_ADVANCE: begin
        for (p = 0; p < k_eff && !hit; p++) begin
          v = comb_now[p];
          if (v > p) begin
            for (q = 0; q <= p; q++) comb_now[q] = cng_pkg::VAL_W'(v - 1 - (p - q));
            hit = 1'b1;
          end
        end
        if (!hit && k_eff > 0) begin
          for (q = 0; q < k_eff; q++) comb_now[q] = cng_pkg::VAL_W'(n_eff - k_eff + q);
          wrap = 1'b1;
        end
      end
      cng_pkg::OP_CLEAR: begin
        foreach (comb_now[i]) comb_now[i] = '0;
      end
      cng_pkg::OP_LOAD: begin
        comb_now[pos] = val;
      end
      default: ;
    endcase
    if (push_it)
      for (p = 0; p < k_eff; p++)
        pending_elems.push_back('{cng_pkg::POS_W'(p), comb_now[p], p == k_eff - 1, wrap});
  endfunction

  task automatic write_reg(input logic [cng_pkg::IDX_W-1:0] idx,
                           input logic [cng_pkg::N_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == cng_pkg::REG_TOTAL_VALUES) total_n = data;
    else if (idx == cng_pkg::REG_CHOSEN_COUNT) chosen_k = data[cng_pkg::K_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_item(input cng_pkg::opcode_t op, input logic [cng_pkg::POS_W-1:0] pos,
                           input logic [cng_pkg::VAL_W-1:0] val, input row_t row);
    logic [cng_pkg::VAL_W-1:0] vals [DIRECT_K];
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= cng_pkg::IN_TDATA_W'({val, pos, op});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    compute_run(op, pos, val, !row.typed);
    if (row.typed) begin
      vals = '{row.v0, row.v1, row.v2};
      for (int i = 0; i < DIRECT_K; i++)
        pending_elems.push_back('{cng_pkg::POS_W'(i), vals[i], i == DIRECT_K - 1, row.wrap});
    end
    @(negedge clk);
  endtask

  // stop offering, wait for every queued element, then let the block settle
  task automatic drain(input int settle);
    s_tvalid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // output check and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_elems.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected transfer: pos %0d val %0d last %0b wrap %0b",
                     m_tdata[3:0], m_tdata[9:4], m_tlast, m_tuser[0]);
        end else begin
          want = pending_elems.pop_front();
          if (m_tdata[3:0] !== want.pos || m_tdata[9:4] !== want.val ||
              m_tlast !== want.last || m_tuser[0] !== want.wrapped) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"mismatch: expected pos %0d val %0d last %0b wrap %0b, ",
                        "got %0d %0d %0b %0b"},
                       want.pos, want.val, want.last, want.wrapped,
                       m_tdata[3:0], m_tdata[9:4], m_tlast, m_tuser[0]);
          end
        end
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    row_t                      no_row;
    cng_pkg::opcode_t          op;
    int                        r, n_eff;
    logic [cng_pkg::POS_W-1:0] pos;
    logic [cng_pkg::VAL_W-1:0] val;
    no_row = '{cng_pkg::OP_NONE, '0, '0, 1'b0, 1'b0, '0, '0, '0};
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (script[i]) send_item(script[i].op, script[i].pos, script[i].val, script[i]);
    drain(SETTLE_CYCLES);

    foreach (plan[ph]) begin
      write_reg(cng_pkg::REG_TOTAL_VALUES, plan[ph].n);
      write_reg(cng_pkg::REG_CHOSEN_COUNT,
                {cng_pkg::N_W - cng_pkg::K_W == 2 ? 2'($urandom_range(3)) : 2'b0,
                 plan[ph].k});
      write_reg(REG_SPARE, cng_pkg::N_W'($urandom_range(127)));
      send_idle_pct = send_pct_of[plan[ph].mode];
      recv_stall_pct <= recv_pct_of[plan[ph].mode];
      if (plan[ph].hold) hold_requests <= hold_requests + 1;
      n_eff = (total_n > cng_pkg::N_SAT) ? int'(cng_pkg::N_SAT) : int'(total_n);
      if (n_eff == 0) n_eff = 1 << cng_pkg::VAL_W;
      for (int i = 0; i < plan[ph].count; i++) begin
        if (plan[ph].pause && i == plan[ph].count / 2) drain(0);
        r = $urandom_range(99);
        pos = cng_pkg::POS_W'($urandom_range(cng_pkg::K_MAX - 1));
        if ($urandom_range(3) == 0) val = cng_pkg::VAL_W'($urandom_range(63));
        else val = cng_pkg::VAL_W'($urandom_range(n_eff - 1));
        if (r < 60) op = cng_pkg::OP_ADVANCE;
        else if (r < 70) op = cng_pkg::OP_CLEAR;
        else if (r < 95) op = cng_pkg::OP_LOAD;
        else op = cng_pkg::OP_NONE;
        send_item(op, pos, val, no_row);
      end
      drain(SETTLE_CYCLES);
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/cng_pkg.sv
src/cng_cell.sv
src/next_combination_generator.sv
src/cng_checker.sv
test/tb_top.sv
